// File: src/vah_pkg.sv
package vah_pkg;

    localparam int MAX_ARRAYS_DEF  = 256;
    localparam int STORE_WORDS_DEF = 4096;
    localparam int WORD_BITS_DEF   = 32;

    localparam int FIELD_BITS = 32;
    localparam int ALU_W      = 34;

    typedef enum logic [1:0] {
        OP_NEW   = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STORE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NEG_COUNT = 3'd1,
        STS_BAD_REF   = 3'd2,
        STS_BAD_INDEX = 3'd3,
        STS_NO_MEMORY = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        SEL_NONE   = 3'd0,
        SEL_NA_SUM = 3'd1,
        SEL_NA_FIT = 3'd2,
        SEL_REF    = 3'd3,
        SEL_IDX    = 3'd4,
        SEL_ADDR   = 3'd5
    } alu_sel_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_REF  = 2'd1,
        SRC_WORD = 2'd2
    } res_src_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_NA_FIT,
        S_IDX_CHK,
        S_ADDR,
        S_LOAD_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        opcode_t opcode;
        logic    in_valid;
        logic    count_neg;
        logic    ref_neg;
        logic    idx_neg;
        logic    alu_neg;
        logic    tbl_full;
        logic    clr_last;
        logic    out_free;
    } vah_flags_t;

    typedef struct packed {
        logic     in_ready;
        alu_sel_t alu_sel;
        logic     sum_keep;
        logic     desc_rd;
        logic     alloc;
        logic     word_rd;
        logic     word_wr;
        logic     clr_wr;
        logic     res_we;
        status_t  res_status;
        logic     res_has;
        res_src_t res_src;
        logic     emit;
    } vah_ctrl_t;

endpackage

// File: src/vah_ram.sv
module vah_ram
    import vah_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = STORE_WORDS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vah_alu.sv
module vah_alu
    import vah_pkg::*;
(
    input  alu_op_t            op,
    input  logic signed [ALU_W-1:0] a,
    input  logic signed [ALU_W-1:0] b,
    output logic signed [ALU_W-1:0] y,
    output logic               neg
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

    assign neg = y[ALU_W-1];

endmodule

// File: src/vah_ctrl.sv
module vah_ctrl
    import vah_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vah_flags_t flags,
    output vah_ctrl_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (flags.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (flags.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (flags.opcode)
                    OP_NEW:
                    begin
                        state_next = flags.count_neg ? S_EMIT : S_NA_FIT;
                    end
                    OP_LOAD, OP_STORE:
                    begin
                        state_next = (flags.ref_neg || !flags.alu_neg) ? S_EMIT : S_IDX_CHK;
                    end
                    OP_NONE:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_NA_FIT:
            begin
                state_next = S_EMIT;
            end
            S_IDX_CHK:
            begin
                state_next = (flags.idx_neg || !flags.alu_neg) ? S_EMIT : S_ADDR;
            end
            S_ADDR:
            begin
                state_next = (flags.opcode == OP_LOAD) ? S_LOAD_WAIT : S_EMIT;
            end
            S_LOAD_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (flags.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.alu_sel    = SEL_NONE;
        ctrl.res_status = STS_OK;
        ctrl.res_src    = SRC_ZERO;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            S_DECODE:
            begin
                unique case (flags.opcode)
                    OP_NEW:
                    begin
                        if (flags.count_neg)
                        begin
                            ctrl.res_we     = 1'b1;
                            ctrl.res_status = STS_NEG_COUNT;
                        end
                        else
                        begin
                            ctrl.alu_sel  = SEL_NA_SUM;
                            ctrl.sum_keep = 1'b1;
                        end
                    end
                    OP_LOAD, OP_STORE:
                    begin
                        ctrl.alu_sel = SEL_REF;
                        if (flags.ref_neg || !flags.alu_neg)
                        begin
                            ctrl.res_we     = 1'b1;
                            ctrl.res_status = STS_BAD_REF;
                        end
                        else
                        begin
                            ctrl.desc_rd = 1'b1;
                        end
                    end
                    OP_NONE:
                    begin
                        ctrl.res_we = 1'b1;
                    end
                endcase
            end
            S_NA_FIT:
            begin
                ctrl.alu_sel = SEL_NA_FIT;
                ctrl.res_we  = 1'b1;
                if (flags.tbl_full || flags.alu_neg)
                begin
                    ctrl.res_status = STS_NO_MEMORY;
                end
                else
                begin
                    ctrl.alloc   = 1'b1;
                    ctrl.res_has = 1'b1;
                    ctrl.res_src = SRC_REF;
                end
            end
            S_IDX_CHK:
            begin
                ctrl.alu_sel = SEL_IDX;
                if (flags.idx_neg || !flags.alu_neg)
                begin
                    ctrl.res_we     = 1'b1;
                    ctrl.res_status = STS_BAD_INDEX;
                end
            end
            S_ADDR:
            begin
                ctrl.alu_sel = SEL_ADDR;
                if (flags.opcode == OP_LOAD)
                begin
                    ctrl.word_rd = 1'b1;
                end
                else
                begin
                    ctrl.word_wr = 1'b1;
                    ctrl.res_we  = 1'b1;
                end
            end
            S_LOAD_WAIT:
            begin
                ctrl.res_we  = 1'b1;
                ctrl.res_has = 1'b1;
                ctrl.res_src = SRC_WORD;
            end
            S_EMIT:
            begin
                ctrl.emit = flags.out_free;
            end
            default:
            begin
                ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/vm_array_heap_unit.sv
// Array heap for a stack machine: newarray bump-allocates words from a shared
// store and returns a reference; load and store bounds-check the reference and
// the index, then touch one word. Items are handled one at a time by a small
// sequencer around a single add/subtract unit and two synchronous RAMs (the
// descriptor table and the word store). A load steps through descriptor read,
// index check, address add, word read and emit before the next item can be
// accepted; a store skips the word read, newarray does a size add, a fit check
// and emit, and rejected items stop early; a result waiting on the output may
// hold the next item in the emit state. After reset the word store is zeroed
// one word per cycle, so the input stays not ready until the clear is done.
module vm_array_heap_unit
    import vah_pkg::*;
#(
    parameter int MAX_ARRAYS  = MAX_ARRAYS_DEF,
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // count, array_ref, elem_index, store_value
    input  logic [127:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value
    output logic [31:0]  m_axis_tdata,
    // status, has_value
    output logic [3:0]   m_axis_tuser
);

    localparam int REF_BITS  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_ARRAYS + 1);
    localparam int WADDR_BITS = $clog2(STORE_WORDS);
    localparam int BASE_BITS = WADDR_BITS;
    localparam int LEN_BITS  = $clog2(STORE_WORDS + 1);
    localparam int DESC_BITS = BASE_BITS + LEN_BITS;

    vah_flags_t flags;
    vah_ctrl_t  ctrl;

    opcode_t                 op_reg;
    logic signed [FIELD_BITS-1:0] count_reg;
    logic signed [FIELD_BITS-1:0] ref_reg;
    logic signed [FIELD_BITS-1:0] idx_reg;
    logic signed [FIELD_BITS-1:0] store_reg;

    logic [CNT_BITS-1:0]   arrays_reg;
    logic [CNT_BITS-1:0]   arrays_next;
    logic [LEN_BITS-1:0]   free_reg;
    logic [LEN_BITS-1:0]   free_next;
    logic [WADDR_BITS-1:0] clr_reg;
    logic [WADDR_BITS-1:0] clr_next;
    logic signed [ALU_W-1:0] sum_reg;

    status_t     res_status_reg;
    logic        res_has_reg;
    logic [31:0] res_value_reg;
    logic [31:0] res_value_next;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [3:0]  m_user_reg;
    logic [31:0] m_data_reg;

    alu_op_t                 alu_op;
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    logic signed [ALU_W-1:0] alu_y;
    logic                    alu_neg;

    logic [DESC_BITS-1:0]  desc_wdata;
    logic [DESC_BITS-1:0]  desc_rdata;
    logic [BASE_BITS-1:0]  desc_base;
    logic [LEN_BITS-1:0]   desc_len;

    logic                  word_we;
    logic [WADDR_BITS-1:0] word_waddr;
    logic [WORD_BITS-1:0]  word_wdata;
    logic [WORD_BITS-1:0]  word_rdata;

    logic accept;

    assign accept = s_axis_tvalid && ctrl.in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode_t'(s_axis_tuser);
            count_reg <= s_axis_tdata[31:0];
            ref_reg   <= s_axis_tdata[63:32];
            idx_reg   <= s_axis_tdata[95:64];
            store_reg <= s_axis_tdata[127:96];
        end
        if (ctrl.sum_keep)
        begin
            sum_reg <= alu_y;
        end
        if (ctrl.res_we)
        begin
            res_status_reg <= ctrl.res_status;
            res_has_reg    <= ctrl.res_has;
            res_value_reg  <= res_value_next;
        end
        if (ctrl.emit)
        begin
            m_user_reg <= {res_has_reg, res_status_reg};
            m_data_reg <= res_value_reg;
        end
    end

    always_comb
    begin
        unique case (ctrl.res_src)
            SRC_REF:  res_value_next = 32'(arrays_reg);
            SRC_WORD: res_value_next = 32'(word_rdata);
            default:  res_value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrays_reg  <= '0;
            free_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            arrays_reg  <= arrays_next;
            free_reg    <= free_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign arrays_next  = ctrl.alloc ? arrays_reg + CNT_BITS'(1) : arrays_reg;
    assign free_next    = ctrl.alloc ? sum_reg[LEN_BITS-1:0] : free_reg;
    assign clr_next     = ctrl.clr_wr ? clr_reg + WADDR_BITS'(1) : clr_reg;
    assign m_valid_next = ctrl.emit ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (ctrl.alu_sel)
            SEL_NA_SUM:
            begin
                alu_op = ALU_ADD;
                alu_a  = {{(ALU_W-FIELD_BITS){count_reg[FIELD_BITS-1]}}, count_reg};
                alu_b  = {{(ALU_W-LEN_BITS){1'b0}}, free_reg};
            end
            SEL_NA_FIT:
            begin
                alu_a = ALU_W'(STORE_WORDS);
                alu_b = sum_reg;
            end
            SEL_REF:
            begin
                alu_a = {{(ALU_W-FIELD_BITS){ref_reg[FIELD_BITS-1]}}, ref_reg};
                alu_b = {{(ALU_W-CNT_BITS){1'b0}}, arrays_reg};
            end
            SEL_IDX:
            begin
                alu_a = {{(ALU_W-FIELD_BITS){idx_reg[FIELD_BITS-1]}}, idx_reg};
                alu_b = {{(ALU_W-LEN_BITS){1'b0}}, desc_len};
            end
            SEL_ADDR:
            begin
                alu_op = ALU_ADD;
                alu_a  = {{(ALU_W-BASE_BITS){1'b0}}, desc_base};
                alu_b  = {{(ALU_W-FIELD_BITS){idx_reg[FIELD_BITS-1]}}, idx_reg};
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    vah_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y),
        .neg (alu_neg)
    );

    assign desc_wdata = {count_reg[LEN_BITS-1:0], free_reg[BASE_BITS-1:0]};
    assign desc_base  = desc_rdata[BASE_BITS-1:0];
    assign desc_len   = desc_rdata[DESC_BITS-1:BASE_BITS];

    vah_ram #(
        .WIDTH (DESC_BITS),
        .DEPTH (MAX_ARRAYS)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ctrl.alloc),
        .waddr (arrays_reg[REF_BITS-1:0]),
        .wdata (desc_wdata),
        .re    (ctrl.desc_rd),
        .raddr (ref_reg[REF_BITS-1:0]),
        .rdata (desc_rdata)
    );

    assign word_we    = ctrl.word_wr || ctrl.clr_wr;
    assign word_waddr = ctrl.clr_wr ? clr_reg : alu_y[WADDR_BITS-1:0];
    assign word_wdata = ctrl.clr_wr ? '0 : WORD_BITS'(store_reg);

    vah_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .re    (ctrl.word_rd),
        .raddr (alu_y[WADDR_BITS-1:0]),
        .rdata (word_rdata)
    );

    assign flags.opcode    = op_reg;
    assign flags.in_valid  = s_axis_tvalid;
    assign flags.count_neg = count_reg[FIELD_BITS-1];
    assign flags.ref_neg   = ref_reg[FIELD_BITS-1];
    assign flags.idx_neg   = idx_reg[FIELD_BITS-1];
    assign flags.alu_neg   = alu_neg;
    assign flags.tbl_full  = (arrays_reg == CNT_BITS'(MAX_ARRAYS));
    assign flags.clr_last  = (clr_reg == WADDR_BITS'(STORE_WORDS - 1));
    assign flags.out_free  = !m_valid_reg || m_axis_tready;

    vah_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule
